FILE: hdl/led_blink_pattern_sequencer_assert.svh
// ----------------------------------------------------------------------------
// LED blink pattern sequencer assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define LBPS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted
`define LBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lbps_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer package
// Field types, command codes and LED word constants.
// ----------------------------------------------------------------------------
package lbps_pkg;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic LED_SYS = 1'b0;
	localparam logic LED_ALM = 1'b1;

	localparam logic [1:0] COLOR_OFF     = 2'd0;
	localparam logic [1:0] COLOR_RED     = 2'd1;
	localparam logic [1:0] COLOR_GREEN   = 2'd2;
	localparam logic [1:0] COLOR_INVALID = 2'd3;

	localparam logic [1:0] MODE_STEADY = 2'd0;
	localparam logic [1:0] MODE_SLOW   = 2'd1;
	localparam logic [1:0] MODE_FAST   = 2'd2;
	localparam logic [1:0] MODE_HW     = 2'd3;

	localparam logic [3:0] SYS_MASK       = 4'hC;
	localparam logic [3:0] ALM_MASK       = 4'h3;
	localparam logic [3:0] LAST_WR_RESET  = 4'h3;

	typedef struct packed {
		logic       operation;
		logic       led_select;
		logic [1:0] color;
		logic [1:0] blink_mode;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] led_value;
		logic       led_write;
		logic       hw_blink;
	} result_t;

	// Lit bits of one LED in the 4-bit word (system in 3:2, alarm in 1:0)
	function automatic logic [3:0] lit_bits(input logic led, input logic [1:0] color);
		logic [3:0] bits;
		bits = (led == LED_SYS) ? {color, 2'b00} : {2'b00, color};
		return bits;
	endfunction

endpackage

FILE: hdl/lbps_core.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer core
// Per-LED colour/mode state, slot index and last-written word; forms the
// result of one item and commits the state update when fire is high.
// ----------------------------------------------------------------------------
module lbps_core #(
	parameter int SLOT_COUNT = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lbps_pkg::item_t  item,
	output lbps_pkg::result_t result
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(SLOT_COUNT / 2);

	// Every slot of an LED is rewritten together, so each slot's word follows
	// from the LED's colour and mode alone.
	logic [1:0]       sys_color_q, sys_mode_q, alm_color_q, alm_mode_q;
	logic [1:0]       sys_color_d, sys_mode_d, alm_color_d, alm_mode_d;
	logic [IDX_W-1:0] idx_q, idx_d, idx_next;
	logic [3:0]       last_q, last_d;
	logic             hw_q, hw_d;
	logic [3:0]       word;
	logic             set_ok, changed;

	function automatic logic lit(input logic [1:0] mode, input logic [IDX_W-1:0] i);
		logic on;
		case (mode)
			lbps_pkg::MODE_SLOW: on = (i < HALF_IDX);
			lbps_pkg::MODE_FAST: on = i[0];
			default:             on = 1'b1;
		endcase
		return on;
	endfunction

	function automatic logic [3:0] slot_word(input logic [1:0] sc, input logic [1:0] sm,
			input logic [1:0] ac, input logic [1:0] am, input logic [IDX_W-1:0] i);
		logic [3:0] w;
		w = (lit(sm, i) ? lbps_pkg::lit_bits(lbps_pkg::LED_SYS, sc) : 4'h0)
			| (lit(am, i) ? lbps_pkg::lit_bits(lbps_pkg::LED_ALM, ac) : 4'h0);
		return w;
	endfunction

	assign set_ok   = (item.operation == lbps_pkg::OP_SET)
		&& (item.color != lbps_pkg::COLOR_INVALID);
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	always_comb begin
		sys_color_d = sys_color_q;
		sys_mode_d  = sys_mode_q;
		alm_color_d = alm_color_q;
		alm_mode_d  = alm_mode_q;
		hw_d        = hw_q;
		idx_d       = idx_q;
		if (set_ok) begin
			if (item.led_select == lbps_pkg::LED_SYS) begin
				sys_color_d = item.color;
				sys_mode_d  = item.blink_mode;
				hw_d        = (item.blink_mode == lbps_pkg::MODE_HW);
			end else begin
				alm_color_d = item.color;
				alm_mode_d  = item.blink_mode;
			end
		end
		if (item.operation == lbps_pkg::OP_TICK) begin
			idx_d = idx_next;
		end
		word    = slot_word(sys_color_d, sys_mode_d, alm_color_d, alm_mode_d, idx_d);
		changed = (item.operation == lbps_pkg::OP_TICK) && (word != last_q);
		last_d  = changed ? word : last_q;
	end

	assign result.accepted  = set_ok;
	assign result.led_value = word;
	assign result.led_write = changed;
	assign result.hw_blink  = hw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_color_q <= lbps_pkg::COLOR_OFF;
			sys_mode_q  <= lbps_pkg::MODE_STEADY;
			alm_color_q <= lbps_pkg::COLOR_OFF;
			alm_mode_q  <= lbps_pkg::MODE_STEADY;
			idx_q       <= '0;
			last_q      <= lbps_pkg::LAST_WR_RESET;
			hw_q        <= 1'b0;
		end else if (fire) begin
			sys_color_q <= sys_color_d;
			sys_mode_q  <= sys_mode_d;
			alm_color_q <= alm_color_d;
			alm_mode_q  <= alm_mode_d;
			idx_q       <= idx_d;
			last_q      <= last_d;
			hw_q        <= hw_d;
		end
	end

endmodule

FILE: hdl/led_blink_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer
// Blink pattern generator for a system and an alarm bicolour LED.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: tuser = 0 sets colour and blink mode of one
//   LED, tuser = 1 is one 100 ms tick. Every command gives exactly one result
//   transaction on the master stream.
//   Master tdata reports whether a set was applied, the 4-bit LED word of the
//   current slot, a write strobe when a tick changed the word, and the system
//   LED hardware-blink flag.
//   Each command is held in the input register and its result in the result
//   register, which drives m_tvalid and m_tdata.
//   Throughput: one command per cycle unless m_tready stalls; the state update
//   is a single pass of logic between the input register and the result register.
//   Reset: both LEDs off, slot index zero, last written word 3, hardware
//   blink flag clear; both registers empty.
//   Stall: while m_tready is low the result holds, the input register still
//   takes one command, and s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer #(
	parameter int SLOT_COUNT = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [0] led_select, [2:1] color, [4:3] blink_mode, [7:5] zero
	input  logic [0:0] s_tuser,  // [0] operation
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [0] accepted, [4:1] led_value, [5] led_write,
	                             // [6] hw_blink, [7] zero
);

	lbps_pkg::item_t   item_s1;
	logic              valid_s1;
	lbps_pkg::result_t result;
	lbps_pkg::result_t result_q;
	logic              m_valid_q;
	logic              advance;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation  <= s_tuser[0];
			item_s1.led_select <= s_tdata[0];
			item_s1.color      <= s_tdata[2:1];
			item_s1.blink_mode <= s_tdata[4:3];
		end
	end

	lbps_core #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, result_q.hw_blink, result_q.led_write,
		result_q.led_value, result_q.accepted};

endmodule

FILE: hdl/lbps_checker.sv
// ----------------------------------------------------------------------------
// LED blink pattern sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_blink_pattern_sequencer_assert.svh"

module lbps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic [0:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// stalled result transaction holds
	`LBPS_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

	// a set never asks for an LED write
	`LBPS_ASSERT_IMP(a_set_no_write, clk, arst_n, m_tvalid, !(m_tdata[0] && m_tdata[5]), "accepted set with write strobe")

	// input only back-pressured when a result is waiting
	`LBPS_ASSERT_IMP(a_ready_stall, clk, arst_n, !s_tready, m_tvalid, "input stalled with empty output")

	// padding bit stays zero
	`LBPS_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, !m_tdata[7], "result padding set")

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (.*);

FILE: test/led_blink_pattern_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED blink pattern sequencer testbench
// A short table of set and tick commands is followed by about 1600 random
// commands in four pacing phases. Every result transaction is checked field
// by field against a local model of the pattern store or a typed table result.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer_tb;

	localparam int SLOTS = 10;
	localparam int RANDOM_PER_PHASE = 400;

	typedef struct {
		lbps_pkg::item_t   cmd;
		bit                typed;
		lbps_pkg::result_t want;
	} cmd_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [0] led_select, [2:1] color, [4:3] blink_mode, [7:5] zero
	logic [0:0] s_tuser;   // [0] operation
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [0] accepted, [4:1] led_value, [5] led_write, [6] hw_blink

	// local copy of the block's state
	logic [3:0] slot_word [SLOTS];
	int         slot_ptr;
	logic [3:0] last_wr_word;
	logic       hw_flag;

	lbps_pkg::result_t led_word_q [$];
	cmd_row_t          cmd_table [$];
	int                send_idle_pct;
	int                recv_stall_pct;
	int                errors;
	int                n_sets;
	int                n_rejected;
	int                n_ticks;
	int                n_writes;

	led_blink_pattern_sequencer #(
		.SLOT_COUNT(SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void clear_pattern_store();
		for (int i = 0; i < SLOTS; i++)
			slot_word[i] = 4'h0;
		slot_ptr     = 0;
		last_wr_word = lbps_pkg::LAST_WR_RESET;
		hw_flag      = 1'b0;
	endfunction

	// Applies one command to the local state and returns the result it gives
	function automatic lbps_pkg::result_t predict_led_word(input lbps_pkg::item_t cmd);
		lbps_pkg::result_t res;
		logic [3:0]        mask;
		logic [3:0]        on;
		logic              lit;
		int                nxt;
		res = '0;
		if (cmd.operation == lbps_pkg::OP_SET) begin
			if (cmd.color != lbps_pkg::COLOR_INVALID) begin
				mask = (cmd.led_select == lbps_pkg::LED_SYS) ? lbps_pkg::SYS_MASK
					: lbps_pkg::ALM_MASK;
				case (cmd.color)
					lbps_pkg::COLOR_RED:
						on = (cmd.led_select == lbps_pkg::LED_SYS) ? 4'h4 : 4'h1;
					lbps_pkg::COLOR_GREEN:
						on = (cmd.led_select == lbps_pkg::LED_SYS) ? 4'h8 : 4'h2;
					default:
						on = 4'h0;
				endcase
				if (cmd.led_select == lbps_pkg::LED_SYS)
					hw_flag = (cmd.blink_mode == lbps_pkg::MODE_HW);
				for (int i = 0; i < SLOTS; i++) begin
					// slow blink lights the first half, fast blink the odd slots
					case (cmd.blink_mode)
						lbps_pkg::MODE_SLOW: lit = (i < SLOTS / 2);
						lbps_pkg::MODE_FAST: lit = (i % 2 == 1);
						default:             lit = 1'b1;
					endcase
					slot_word[i] = (slot_word[i] & ~mask) | (lit ? on : 4'h0);
				end
				res.accepted = 1'b1;
			end
		end else begin
			nxt = slot_ptr + 1;
			if (nxt >= SLOTS)
				nxt = 0;
			if (slot_word[nxt] != last_wr_word) begin
				last_wr_word  = slot_word[nxt];
				res.led_write = 1'b1;
			end
			slot_ptr = nxt;
		end
		res.led_value = slot_word[slot_ptr];
		res.hw_blink  = hw_flag;
		return res;
	endfunction

	function automatic lbps_pkg::item_t random_command();
		lbps_pkg::item_t c;
		c.operation  = ($urandom_range(99) < 55) ? lbps_pkg::OP_TICK : lbps_pkg::OP_SET;
		c.led_select = 1'($urandom_range(1));
		c.color      = ($urandom_range(9) == 0) ? lbps_pkg::COLOR_INVALID
			: 2'($urandom_range(2));
		c.blink_mode = 2'($urandom_range(3));
		return c;
	endfunction

	task automatic add_row(input logic op, input logic led, input logic [1:0] color,
			input logic [1:0] mode, input bit typed, input lbps_pkg::result_t want);
		cmd_row_t r;
		r.cmd   = '{operation: op, led_select: led, color: color, blink_mode: mode};
		r.typed = typed;
		r.want  = want;
		cmd_table.push_back(r);
	endtask

	// One command transaction; the typed result, where given, replaces the prediction
	task automatic send_command(input lbps_pkg::item_t cmd, input bit typed,
			input lbps_pkg::result_t want);
		lbps_pkg::result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd.operation;
		s_tdata  <= {3'b000, cmd.blink_mode, cmd.color, cmd.led_select};
		do @(posedge clk); while (!s_tready);
		res = predict_led_word(cmd);
		if (cmd.operation == lbps_pkg::OP_TICK) begin
			n_ticks++;
			n_writes += res.led_write;
		end else begin
			n_sets++;
			n_rejected += (cmd.color == lbps_pkg::COLOR_INVALID);
		end
		led_word_q.push_back(typed ? want : res);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (led_word_q.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		lbps_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (led_word_q.size() == 0) begin
				$error("result transaction with none expected, tdata %h", m_tdata);
				errors++;
			end else begin
				want = led_word_q.pop_front();
				if (m_tdata[0] !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, m_tdata[0]);
					errors++;
				end
				if (m_tdata[4:1] !== want.led_value) begin
					$error("led_value: expected %h, got %h", want.led_value, m_tdata[4:1]);
					errors++;
				end
				if (m_tdata[5] !== want.led_write) begin
					$error("led_write: expected %0d, got %0d", want.led_write, m_tdata[5]);
					errors++;
				end
				if (m_tdata[6] !== want.hw_blink) begin
					$error("hw_blink: expected %0d, got %0d", want.hw_blink, m_tdata[6]);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = lbps_pkg::OP_SET;
		m_tready       = 1'b1;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		errors         = 0;
		n_sets         = 0;
		n_rejected     = 0;
		n_ticks        = 0;
		n_writes       = 0;
		clear_pattern_store();

		// fields: accepted, led_value, led_write, hw_blink
		add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_SYS, lbps_pkg::COLOR_OFF,
			lbps_pkg::MODE_STEADY, 1'b1, {1'b0, 4'h0, 1'b1, 1'b0});
		add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_ALM, lbps_pkg::COLOR_INVALID,
			lbps_pkg::MODE_HW, 1'b1, {1'b0, 4'h0, 1'b0, 1'b0});
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_SYS, lbps_pkg::COLOR_INVALID,
			lbps_pkg::MODE_STEADY, 1'b1, {1'b0, 4'h0, 1'b0, 1'b0});
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_SYS, lbps_pkg::COLOR_GREEN,
			lbps_pkg::MODE_HW, 1'b1, {1'b1, 4'h8, 1'b0, 1'b1});
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_ALM, lbps_pkg::COLOR_INVALID,
			lbps_pkg::MODE_HW, 1'b1, {1'b0, 4'h8, 1'b0, 1'b1});
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_ALM, lbps_pkg::COLOR_RED,
			lbps_pkg::MODE_STEADY, 1'b1, {1'b1, 4'h9, 1'b0, 1'b1});
		add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_SYS, lbps_pkg::COLOR_OFF,
			lbps_pkg::MODE_STEADY, 1'b1, {1'b0, 4'h9, 1'b1, 1'b1});
		add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_SYS, lbps_pkg::COLOR_OFF,
			lbps_pkg::MODE_STEADY, 1'b1, {1'b0, 4'h9, 1'b0, 1'b1});
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_SYS, lbps_pkg::COLOR_RED,
			lbps_pkg::MODE_SLOW, 1'b0, '0);
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_ALM, lbps_pkg::COLOR_GREEN,
			lbps_pkg::MODE_FAST, 1'b0, '0);
		for (int i = 0; i < SLOTS; i++)
			add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_SYS, lbps_pkg::COLOR_OFF,
				lbps_pkg::MODE_STEADY, 1'b0, '0);
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_SYS, lbps_pkg::COLOR_OFF,
			lbps_pkg::MODE_FAST, 1'b0, '0);
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_ALM, lbps_pkg::COLOR_OFF,
			lbps_pkg::MODE_SLOW, 1'b0, '0);
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_SYS, lbps_pkg::COLOR_GREEN,
			lbps_pkg::MODE_STEADY, 1'b0, '0);
		add_row(lbps_pkg::OP_SET, lbps_pkg::LED_ALM, lbps_pkg::COLOR_RED,
			lbps_pkg::MODE_HW, 1'b0, '0);
		add_row(lbps_pkg::OP_TICK, lbps_pkg::LED_ALM, lbps_pkg::COLOR_GREEN,
			lbps_pkg::MODE_FAST, 1'b0, '0);

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (cmd_table[i])
			send_command(cmd_table[i].cmd, cmd_table[i].typed, cmd_table[i].want);
		drain_results();

		// pacing phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 28 : 0;
			recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 28 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_command(random_command(), 1'b0, '0);
				if (n == RANDOM_PER_PHASE / 2)
					drain_results();
			end
			drain_results();
		end

		// result register plus input register
		repeat (4) @(posedge clk);
		$display("Ran %0d set commands (%0d with an invalid colour) and %0d ticks,",
			n_sets, n_rejected, n_ticks);
		$display("  giving %0d LED word writes, under four handshake pacing phases.", n_writes);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: led_blink_pattern_sequencer.f
+incdir+hdl
hdl/lbps_pkg.sv
hdl/lbps_core.sv
hdl/led_blink_pattern_sequencer.sv
hdl/lbps_checker.sv
test/led_blink_pattern_sequencer_tb.sv
